[rtl/wsx_pkg.sv]
package wsx_pkg;

	// Field widths of the stream items.
	localparam int ELEMENT_W   = 8;
	localparam int BEST_SUM_W  = 12;
	localparam int BEST_POS_W  = 5;
	localparam int OUT_FIELDS_W = BEST_SUM_W + 2 * BEST_POS_W;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROW_TOTAL = 2'd0,
		CFG_COL_TOTAL = 2'd1,
		CFG_MODE      = 2'd2
	} cfg_index_t;

	typedef enum logic {
		MODE_MAX = 1'b0,
		MODE_MIN = 1'b1
	} mode_t;

	// Window geometry.
	localparam int WIN_DIM  = 3;
	localparam int COLSUM_W = 10;

	// Smallest legal row or column count, also the reset value.
	localparam logic [CFG_DATA_W-1:0] MIN_DIM = 6'd3;

endpackage

[rtl/window_sum_extremum_3x3.sv]
// 3x3 box-sum extremum finder. Matrix elements stream in row-major order on
// s_axis, one element per request, and the block accepts one element every
// clock cycle. Two line stores of MAX_COLS entries each and a three-column
// window of column sums build every complete 3x3 window sum; mode 0 keeps the
// largest, mode 1 the smallest, and on ties the first window in row-major
// order wins. After the final element of a matrix a single result (best sum
// and the top-left row and column of that window) passes stage 1 and stage 2
// and then sits in the output register on m_axis, so input keeps
// flowing while it waits; only when the next matrix's final element reaches
// the compare stage before the previous result is taken does s_axis_tready
// drop. Row and column counts are clamped to 3..MAX_ROWS and 3..MAX_COLS; the user
// writes configuration only while no matrix is in progress, not enforced here.
module window_sum_extremum_3x3
	import wsx_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Element stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [ELEMENT_W-1:0]   s_axis_tdata,   // [7:0] element
	// Result stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] best_sum, [16:12] best_top,
	                                               // [21:17] best_left, [23:22] zero
	// Configuration writes.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RBW = (RW + 1 > CFG_DATA_W + 1) ? RW + 1 : CFG_DATA_W + 1;
	localparam int CBW = (CW + 1 > CFG_DATA_W + 1) ? CW + 1 : CFG_DATA_W + 1;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] row_total_q;
	logic [CFG_DATA_W-1:0] col_total_q;
	mode_t                 mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_total_q <= MIN_DIM;
			col_total_q <= MIN_DIM;
			mode_q      <= MODE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_TOTAL: row_total_q <= cfg_data;
				CFG_COL_TOTAL: col_total_q <= cfg_data;
				CFG_MODE:      mode_q      <= mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	// Clamped matrix bounds.
	logic [RBW-1:0] rows_eff;
	logic [CBW-1:0] cols_eff;

	always_comb begin
		if (row_total_q < MIN_DIM) begin
			rows_eff = RBW'(MIN_DIM);
		end else if (RBW'(row_total_q) > RBW'(MAX_ROWS)) begin
			rows_eff = RBW'(MAX_ROWS);
		end else begin
			rows_eff = RBW'(row_total_q);
		end
		if (col_total_q < MIN_DIM) begin
			cols_eff = CBW'(MIN_DIM);
		end else if (CBW'(col_total_q) > CBW'(MAX_COLS)) begin
			cols_eff = CBW'(MAX_COLS);
		end else begin
			cols_eff = CBW'(col_total_q);
		end
	end

	// Pipeline control: everything moves unless a final item in stage 2
	// would overwrite a result that is neither taken yet nor taken this cycle.
	logic valid_s1, valid_s2;
	logic last_s2;
	logic out_valid_q;
	logic adv;
	logic in_fire;

	assign adv           = !(valid_s2 && last_s2 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = adv;
	assign in_fire       = s_axis_tvalid && adv;

	// Stream position of the next element.
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          last_col, last_row;

	assign last_col = (CBW'(col_q) + CBW'(1)) >= cols_eff;
	assign last_row = (RBW'(row_q) + RBW'(1)) >= rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (last_col && last_row) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= row_q + RW'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: element, its position and the two line store reads.
	logic [ELEMENT_W-1:0] element_s1;
	logic [RW-1:0]        row_s1;
	logic [CW-1:0]        col_s1;
	logic                 last_s1;
	logic                 full_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			element_s1 <= s_axis_tdata;
			row_s1     <= row_q;
			col_s1     <= col_q;
			last_s1    <= last_col && last_row;
			full_s1    <= (row_q >= RW'(WIN_DIM - 1)) && (col_q >= CW'(WIN_DIM - 1));
		end
	end

	// Line stores: read at acceptance, written back when stage 1 moves on.
	// Consecutive elements never share a column, so the read never meets
	// the pending write.
	logic [ELEMENT_W-1:0] older_mem [MAX_COLS];
	logic [ELEMENT_W-1:0] newer_mem [MAX_COLS];
	logic [ELEMENT_W-1:0] rd_older_s1;
	logic [ELEMENT_W-1:0] rd_newer_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_older_s1 <= older_mem[col_q];
			rd_newer_s1 <= newer_mem[col_q];
		end
		if (adv && valid_s1) begin
			older_mem[col_s1] <= rd_newer_s1;
			newer_mem[col_s1] <= element_s1;
		end
	end

	// Stage 2: the window kept as three column sums, newest in slot 2.
	logic [COLSUM_W-1:0] colsum_s2 [WIN_DIM];
	logic [COLSUM_W-1:0] new_colsum;
	logic [RW-1:0]       row_s2;
	logic [CW-1:0]       col_s2;
	logic                full_s2;

	assign new_colsum = COLSUM_W'(rd_older_s1) + COLSUM_W'(rd_newer_s1)
		+ COLSUM_W'(element_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			colsum_s2[0] <= colsum_s2[1];
			colsum_s2[1] <= colsum_s2[2];
			colsum_s2[2] <= new_colsum;
			row_s2       <= row_s1;
			col_s2       <= col_s1;
			last_s2      <= last_s1;
			full_s2      <= full_s1;
		end
	end

	// Window sum and comparison against the best so far.
	logic [BEST_SUM_W-1:0] win_sum;
	logic [BEST_SUM_W-1:0] best_value_q, next_value;
	logic [RW-1:0]         best_row_q, next_row;
	logic [CW-1:0]         best_col_q, next_col;
	logic                  have_best_q;
	logic                  take;

	assign win_sum = BEST_SUM_W'(colsum_s2[0]) + BEST_SUM_W'(colsum_s2[1])
		+ BEST_SUM_W'(colsum_s2[2]);

	always_comb begin
		take = full_s2 && (!have_best_q
			|| (mode_q == MODE_MAX && win_sum > best_value_q)
			|| (mode_q == MODE_MIN && win_sum < best_value_q));
		next_value = best_value_q;
		next_row   = best_row_q;
		next_col   = best_col_q;
		if (take) begin
			next_value = win_sum;
			next_row   = row_s2 - RW'(WIN_DIM - 1);
			next_col   = col_s2 - CW'(WIN_DIM - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q <= '0;
			best_row_q   <= '0;
			best_col_q   <= '0;
			have_best_q  <= 1'b0;
		end else if (adv && valid_s2) begin
			if (last_s2) begin
				best_value_q <= '0;
				best_row_q   <= '0;
				best_col_q   <= '0;
				have_best_q  <= 1'b0;
			end else begin
				best_value_q <= next_value;
				best_row_q   <= next_row;
				best_col_q   <= next_col;
				have_best_q  <= have_best_q || take;
			end
		end
	end

	// Result register.
	logic [BEST_SUM_W-1:0] out_sum_q;
	logic [BEST_POS_W-1:0] out_top_q;
	logic [BEST_POS_W-1:0] out_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && last_s2) begin
			out_sum_q  <= next_value;
			out_top_q  <= BEST_POS_W'(next_row);
			out_left_q <= BEST_POS_W'(next_col);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_left_q, out_top_q, out_sum_q};

endmodule
